[hdl/sdtc_pkg.sv]
// Package for the stepper drive tick controller: word types, register map,
// reset values, sequence codes and the half-step coil table.
// No dependencies; every other file uses it by scoped names.
package sdtc_pkg;

	// Register map (index = paddr[4:2])
	localparam int unsigned ADDR_W = 5;
	localparam logic [2:0] REG_ADC_HIGH  = 3'd0;
	localparam logic [2:0] REG_ADC_LOW   = 3'd1;
	localparam logic [2:0] REG_STOP_DIST = 3'd2;
	localparam logic [2:0] REG_GO_DIST   = 3'd3;
	localparam logic [2:0] REG_JOY_PER   = 3'd4;
	localparam logic [2:0] REG_MOT_PER   = 3'd5;
	localparam logic [2:0] REG_TICK_STEP = 3'd6;

	// Register reset values
	localparam logic [9:0]  ADC_HIGH_RST  = 10'd700;
	localparam logic [9:0]  ADC_LOW_RST   = 10'd300;
	localparam logic [7:0]  STOP_DIST_RST = 8'd8;
	localparam logic [7:0]  GO_DIST_RST   = 8'd20;
	localparam logic [11:0] JOY_PER_RST   = 12'd90;
	localparam logic [11:0] MOT_PER_RST   = 12'd3;
	localparam logic [7:0]  TICK_STEP_RST = 8'd3;

	// Elapsed counters saturate here
	localparam logic [12:0] ELAPSED_MAX = 13'd8191;

	// Sequencer codes: stop, phases 1..8, not yet started
	localparam logic [3:0] SEQ_STOP     = 4'd0;
	localparam logic [3:0] SEQ_CW_ENTRY = 4'd8;
	localparam logic [3:0] SEQ_CCW_ENTRY = 4'd2;
	localparam logic [3:0] SEQ_LAST     = 4'd8;
	localparam logic [3:0] SEQ_UNSTARTED = 4'd9;

	// Direction flag masks
	localparam logic [3:0] DIR_UP    = 4'd1;
	localparam logic [3:0] DIR_DOWN  = 4'd2;
	localparam logic [3:0] DIR_LEFT  = 4'd4;
	localparam logic [3:0] DIR_RIGHT = 4'd8;

	// Speed advice codes
	localparam logic [1:0] ADV_STOP = 2'd0;
	localparam logic [1:0] ADV_SLOW = 2'd1;
	localparam logic [1:0] ADV_GO   = 2'd2;

	typedef struct packed {
		logic [9:0] adc_vertical;
		logic [9:0] adc_horizontal;
		logic [7:0] obstacle_distance;
	} tick_t;

	typedef struct packed {
		logic [3:0] upper_right_coils;
		logic [3:0] upper_left_coils;
		logic [3:0] bottom_left_coils;
		logic [3:0] bottom_right_coils;
		logic [1:0] speed_advice;
	} drive_t;

	typedef struct packed {
		logic [9:0]  adc_high;
		logic [9:0]  adc_low;
		logic [7:0]  stop_dist;
		logic [7:0]  go_dist;
		logic [11:0] joy_period;
		logic [11:0] mot_period;
		logic [7:0]  tick_step;
	} cfg_t;

	typedef struct packed {
		logic [3:0]  seq;
		logic [3:0]  coils;
		logic        enable;
		logic        cw;
		logic [3:0]  dir;
		logic [12:0] joy_elapsed;
		logic [12:0] mot_elapsed;
		logic [3:0]  port_ur;
		logic [3:0]  port_ul;
		logic [3:0]  port_bl;
		logic [3:0]  port_br;
	} state_t;

	// Half-step coil pattern for phase 0..7
	function automatic logic [3:0] coil_of(input logic [2:0] ph);
		logic [3:0] c;
		case (ph)
			3'd0: c = 4'd1;
			3'd1: c = 4'd3;
			3'd2: c = 4'd2;
			3'd3: c = 4'd6;
			3'd4: c = 4'd4;
			3'd5: c = 4'd12;
			3'd6: c = 4'd8;
			default: c = 4'd9;
		endcase
		return c;
	endfunction

endpackage

[hdl/sdtc_tick_logic.sv]
// Per-tick next-state and result logic: joystick decode, distance
// classifier, half-step sequencer and coil routing. Uses sdtc_pkg.
// Purely combinational; the top level registers state and result.
module sdtc_tick_logic (
	input  sdtc_pkg::cfg_t   cfg,
	input  sdtc_pkg::state_t st,
	input  sdtc_pkg::tick_t  tick,
	output sdtc_pkg::state_t st_next,
	output sdtc_pkg::drive_t result
);

	// add tick_step, saturate at the counter max
	function automatic logic [12:0] advance(input logic [12:0] e, input logic [7:0] step);
		logic [13:0] sum;
		sum = {1'b0, e} + {6'd0, step};
		return (sum > {1'b0, sdtc_pkg::ELAPSED_MAX}) ? sdtc_pkg::ELAPSED_MAX : sum[12:0];
	endfunction

	logic       joy_due, mot_due;
	logic [3:0] dir_n;
	logic       en_n, cw_n;
	logic [2:0] ph, ph_n;
	logic [3:0] seq_n, coils_n;
	logic [1:0] advice;
	logic       up, down, left, right;

	assign joy_due = st.joy_elapsed >= {1'b0, cfg.joy_period};
	assign mot_due = st.mot_elapsed >= {1'b0, cfg.mot_period};

	// joystick decode, vertical axis has priority
	always_comb begin
		dir_n = st.dir;
		en_n  = st.enable;
		cw_n  = st.cw;
		if (joy_due) begin
			if (tick.adc_vertical > cfg.adc_high) begin
				dir_n = sdtc_pkg::DIR_UP; en_n = 1'b1; cw_n = 1'b1;
			end else if (tick.adc_vertical < cfg.adc_low) begin
				dir_n = sdtc_pkg::DIR_DOWN; en_n = 1'b1; cw_n = 1'b0;
			end else if (tick.adc_horizontal > cfg.adc_high) begin
				dir_n = sdtc_pkg::DIR_RIGHT; en_n = 1'b1; cw_n = 1'b0;
			end else if (tick.adc_horizontal < cfg.adc_low) begin
				dir_n = sdtc_pkg::DIR_LEFT; en_n = 1'b1; cw_n = 1'b1;
			end else begin
				en_n = 1'b0;
			end
		end
	end

	// distance classifier, stop wins over go
	always_comb begin
		if (tick.obstacle_distance <= cfg.stop_dist)
			advice = sdtc_pkg::ADV_STOP;
		else if (tick.obstacle_distance < cfg.go_dist)
			advice = sdtc_pkg::ADV_SLOW;
		else
			advice = sdtc_pkg::ADV_GO;
	end

	// half-step sequencer; clockwise walks the phases backward
	assign ph   = 3'(st.seq - 4'd1);
	assign ph_n = cw_n ? (ph - 3'd1) : (ph + 3'd1);

	always_comb begin
		seq_n   = st.seq;
		coils_n = st.coils;
		if (mot_due) begin
			if (st.seq == sdtc_pkg::SEQ_STOP)
				seq_n = en_n ? (cw_n ? sdtc_pkg::SEQ_CW_ENTRY : sdtc_pkg::SEQ_CCW_ENTRY)
				             : sdtc_pkg::SEQ_STOP;
			else if (st.seq <= sdtc_pkg::SEQ_LAST)
				seq_n = en_n ? ({1'b0, ph_n} + 4'd1) : sdtc_pkg::SEQ_STOP;
			else
				seq_n = sdtc_pkg::SEQ_STOP;
			if (seq_n != sdtc_pkg::SEQ_STOP && seq_n <= sdtc_pkg::SEQ_LAST)
				coils_n = sdtc_pkg::coil_of(3'(seq_n - 4'd1));
		end
	end

	// routing to motor groups
	assign up    = dir_n[0];
	assign down  = dir_n[1];
	assign left  = dir_n[2];
	assign right = dir_n[3];

	always_comb begin
		st_next             = st;
		st_next.dir         = dir_n;
		st_next.enable      = en_n;
		st_next.cw          = cw_n;
		st_next.seq         = seq_n;
		st_next.coils       = coils_n;
		st_next.joy_elapsed = advance(joy_due ? 13'd0 : st.joy_elapsed, cfg.tick_step);
		st_next.mot_elapsed = advance(mot_due ? 13'd0 : st.mot_elapsed, cfg.tick_step);
		if ((up || down) && !left && !right) begin
			st_next.port_ur = coils_n;
			st_next.port_ul = coils_n;
			st_next.port_bl = coils_n;
			st_next.port_br = coils_n;
		end else if (left && !right && !up && !down) begin
			st_next.port_ur = coils_n;
			st_next.port_br = coils_n;
		end else if (right && !left && !up && !down) begin
			st_next.port_ul = coils_n;
			st_next.port_bl = coils_n;
		end
	end

	always_comb begin
		result.upper_right_coils  = st_next.port_ur;
		result.upper_left_coils   = st_next.port_ul;
		result.bottom_left_coils  = st_next.port_bl;
		result.bottom_right_coils = st_next.port_br;
		result.speed_advice       = advice;
	end

endmodule

[hdl/stepper_drive_tick_controller.sv]
// Top level of the stepper drive tick controller: register file, tick input
// register, controller state and result register. Uses sdtc_pkg and
// sdtc_tick_logic.
//
//   channel  | direction | handshake                  | word
//   ---------+-----------+----------------------------+---------------------
//   tick     | in        | tick_valid / tick_stall    | sdtc_pkg::tick_t
//   drive    | out       | drive_valid / drive_stall  | sdtc_pkg::drive_t
//   config   | in        | APB psel/penable/pwrite    | 32-bit registers
//
// One tick word per clock sustained while drive_stall is low; each word passes
// through the input register, then the result register, where drive_valid rises.
// The tick state updates once per word as it moves into the result register.
// A stalled result holds; one more tick word is held in the input register,
// after which tick_stall rises. Reset is asynchronous and needs no clearing pass.
module stepper_drive_tick_controller (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          tick_valid,
	output logic                          tick_stall,
	input  sdtc_pkg::tick_t               tick,
	output logic                          drive_valid,
	input  logic                          drive_stall,
	output sdtc_pkg::drive_t              drive,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [sdtc_pkg::ADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	sdtc_pkg::cfg_t   cfg_q;
	sdtc_pkg::state_t st_q, st_next;
	sdtc_pkg::tick_t  tick_s1;
	sdtc_pkg::drive_t result, drive_q;
	logic             valid_s1, drive_valid_q;
	logic             accept, advance, cfg_wr;
	logic [2:0]       reg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign reg_idx = paddr[4:2];

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.adc_high   <= sdtc_pkg::ADC_HIGH_RST;
			cfg_q.adc_low    <= sdtc_pkg::ADC_LOW_RST;
			cfg_q.stop_dist  <= sdtc_pkg::STOP_DIST_RST;
			cfg_q.go_dist    <= sdtc_pkg::GO_DIST_RST;
			cfg_q.joy_period <= sdtc_pkg::JOY_PER_RST;
			cfg_q.mot_period <= sdtc_pkg::MOT_PER_RST;
			cfg_q.tick_step  <= sdtc_pkg::TICK_STEP_RST;
		end else if (cfg_wr) begin
			case (reg_idx)
				sdtc_pkg::REG_ADC_HIGH:  cfg_q.adc_high   <= pwdata[9:0];
				sdtc_pkg::REG_ADC_LOW:   cfg_q.adc_low    <= pwdata[9:0];
				sdtc_pkg::REG_STOP_DIST: cfg_q.stop_dist  <= pwdata[7:0];
				sdtc_pkg::REG_GO_DIST:   cfg_q.go_dist    <= pwdata[7:0];
				sdtc_pkg::REG_JOY_PER:   cfg_q.joy_period <= pwdata[11:0];
				sdtc_pkg::REG_MOT_PER:   cfg_q.mot_period <= pwdata[11:0];
				sdtc_pkg::REG_TICK_STEP: cfg_q.tick_step  <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		case (reg_idx)
			sdtc_pkg::REG_ADC_HIGH:  prdata = {22'd0, cfg_q.adc_high};
			sdtc_pkg::REG_ADC_LOW:   prdata = {22'd0, cfg_q.adc_low};
			sdtc_pkg::REG_STOP_DIST: prdata = {24'd0, cfg_q.stop_dist};
			sdtc_pkg::REG_GO_DIST:   prdata = {24'd0, cfg_q.go_dist};
			sdtc_pkg::REG_JOY_PER:   prdata = {20'd0, cfg_q.joy_period};
			sdtc_pkg::REG_MOT_PER:   prdata = {20'd0, cfg_q.mot_period};
			sdtc_pkg::REG_TICK_STEP: prdata = {24'd0, cfg_q.tick_step};
			default:                 prdata = 32'd0;
		endcase
	end

	// handshake: input register drains whenever the result register is free
	assign advance    = valid_s1 && (!drive_valid_q || !drive_stall);
	assign tick_stall = valid_s1 && !advance;
	assign accept     = tick_valid && !tick_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (accept)
			valid_s1 <= 1'b1;
		else if (advance)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept)
			tick_s1 <= tick;
	end

	sdtc_tick_logic u_logic (
		.cfg     (cfg_q),
		.st      (st_q),
		.tick    (tick_s1),
		.st_next (st_next),
		.result  (result)
	);

	// controller state, counters start at their reset periods
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.seq         <= sdtc_pkg::SEQ_UNSTARTED;
			st_q.coils       <= 4'd0;
			st_q.enable      <= 1'b0;
			st_q.cw          <= 1'b0;
			st_q.dir         <= 4'd0;
			st_q.joy_elapsed <= {1'b0, sdtc_pkg::JOY_PER_RST};
			st_q.mot_elapsed <= {1'b0, sdtc_pkg::MOT_PER_RST};
			st_q.port_ur     <= 4'd0;
			st_q.port_ul     <= 4'd0;
			st_q.port_bl     <= 4'd0;
			st_q.port_br     <= 4'd0;
		end else if (advance) begin
			st_q <= st_next;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			drive_valid_q <= 1'b0;
		else if (advance)
			drive_valid_q <= 1'b1;
		else if (!drive_stall)
			drive_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance)
			drive_q <= result;
	end

	assign drive_valid = drive_valid_q;
	assign drive       = drive_q;

endmodule

[hdl/sdtc_checker.sv]
// Port-level checker for the stepper drive tick controller, bound to the
// top level. Uses sdtc_pkg for the word types.
module sdtc_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             tick_valid,
	input logic             tick_stall,
	input logic             drive_valid,
	input logic             drive_stall,
	input sdtc_pkg::drive_t drive
);

	// a stalled result word holds
	a_drive_hold: assert property (@(posedge clk) disable iff (!arst_n)
		drive_valid && drive_stall |=> drive_valid && $stable(drive))
		else $error("drive word changed under stall");

	// input backs up only behind a full, stalled result register
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		tick_stall |-> drive_valid && drive_stall)
		else $error("tick stalled with result side free");

	// a tick stall behind a stalled result holds while a tick is offered and the result stays stalled
	a_stall_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		tick_stall && drive_stall |=> tick_stall || !tick_valid || !drive_stall)
		else $error("tick stall dropped while result still blocked");

	// speed advice code is never the unused value
	a_advice_code: assert property (@(posedge clk) disable iff (!arst_n)
		drive_valid |-> drive.speed_advice != 2'd3)
		else $error("unused speed advice code");

endmodule

bind stepper_drive_tick_controller sdtc_checker u_sdtc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.tick_valid  (tick_valid),
	.tick_stall  (tick_stall),
	.drive_valid (drive_valid),
	.drive_stall (drive_stall),
	.drive       (drive)
);

[tb/sv/testbench.sv]
// Self-checking testbench for stepper_drive_tick_controller: drives tick words,
// predicts every drive word in step with the block and checks it field by field.
// Depends on sdtc_pkg and hdl/stepper_drive_tick_controller.sv.
module testbench;

	localparam int WATCHDOG_LIMIT = 1000;
	localparam int PHASE_ITEMS = 100;
	// half-step coil nibbles, phase 0 in the low nibble
	localparam logic [31:0] HALF_STEP = {4'd9, 4'd8, 4'd12, 4'd4, 4'd6, 4'd2, 4'd3, 4'd1};

	typedef enum int {ZONE_HIGH, ZONE_LOW, ZONE_MID, ZONE_ANY} zone_t;
	typedef enum int {MOVE_UP, MOVE_DOWN, MOVE_RIGHT, MOVE_LEFT, MOVE_NONE} move_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic tick_valid = 1'b0;
	logic tick_stall;
	sdtc_pkg::tick_t tick_in = '0;
	logic drive_valid;
	logic drive_stall = 1'b0;
	sdtc_pkg::drive_t drive_out;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [sdtc_pkg::ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	stepper_drive_tick_controller uut (
		.clk(clk),
		.arst_n(arst_n),
		.tick_valid(tick_valid),
		.tick_stall(tick_stall),
		.tick(tick_in),
		.drive_valid(drive_valid),
		.drive_stall(drive_stall),
		.drive(drive_out),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// Shadow registers and controller state
	sdtc_pkg::cfg_t shadow_cfg;
	logic [3:0] seq_code;
	logic [3:0] coil_now;
	logic run_en;
	logic turn_cw;
	logic [3:0] dir_flags;
	logic [12:0] joy_elapsed;
	logic [12:0] mot_elapsed;
	logic [3:0] port_coils [4];

	sdtc_pkg::tick_t tick_pending [$];
	sdtc_pkg::drive_t drive_expected [$];
	int mismatches = 0;
	int send_gap = 0;
	int stall_left = 0;
	int idle_cycles = 0;
	bit quiet = 1'b0;

	initial begin
		forever #5 clk = ~clk;
	end

	task automatic note_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $time, msg);
		mismatches++;
	endtask

	task automatic check_field(input string name, input logic [3:0] got, input logic [3:0] want);
		if (got !== want)
			note_mismatch($sformatf("%s got %0h, want %0h", name, got, want));
	endtask

	function automatic void reset_model();
		shadow_cfg.adc_high = sdtc_pkg::ADC_HIGH_RST;
		shadow_cfg.adc_low = sdtc_pkg::ADC_LOW_RST;
		shadow_cfg.stop_dist = sdtc_pkg::STOP_DIST_RST;
		shadow_cfg.go_dist = sdtc_pkg::GO_DIST_RST;
		shadow_cfg.joy_period = sdtc_pkg::JOY_PER_RST;
		shadow_cfg.mot_period = sdtc_pkg::MOT_PER_RST;
		shadow_cfg.tick_step = sdtc_pkg::TICK_STEP_RST;
		seq_code = sdtc_pkg::SEQ_UNSTARTED;
		coil_now = '0;
		run_en = 1'b0;
		turn_cw = 1'b0;
		dir_flags = '0;
		joy_elapsed = {1'b0, sdtc_pkg::JOY_PER_RST};
		mot_elapsed = {1'b0, sdtc_pkg::MOT_PER_RST};
		for (int i = 0; i < 4; i++)
			port_coils[i] = '0;
	endfunction

	// Elapsed counter plus tick step, saturating
	function automatic logic [12:0] add_step(input logic [12:0] e);
		logic [13:0] s;
		s = {1'b0, e} + {6'd0, shadow_cfg.tick_step};
		return (s > {1'b0, sdtc_pkg::ELAPSED_MAX}) ? sdtc_pkg::ELAPSED_MAX : s[12:0];
	endfunction

	// One scheduler tick: updates the shadow state, returns the drive word
	function automatic sdtc_pkg::drive_t predict_drive(input sdtc_pkg::tick_t t);
		sdtc_pkg::drive_t r;
		logic [3:0] ns;
		logic [2:0] ph;
		logic up, down, left, right;

		// joystick decode when due
		if (joy_elapsed >= {1'b0, shadow_cfg.joy_period}) begin
			if (t.adc_vertical > shadow_cfg.adc_high) begin
				dir_flags = sdtc_pkg::DIR_UP;
				run_en = 1'b1;
				turn_cw = 1'b1;
			end else if (t.adc_vertical < shadow_cfg.adc_low) begin
				dir_flags = sdtc_pkg::DIR_DOWN;
				run_en = 1'b1;
				turn_cw = 1'b0;
			end else if (t.adc_horizontal > shadow_cfg.adc_high) begin
				dir_flags = sdtc_pkg::DIR_RIGHT;
				run_en = 1'b1;
				turn_cw = 1'b0;
			end else if (t.adc_horizontal < shadow_cfg.adc_low) begin
				dir_flags = sdtc_pkg::DIR_LEFT;
				run_en = 1'b1;
				turn_cw = 1'b1;
			end else
				run_en = 1'b0;
			joy_elapsed = '0;
		end
		joy_elapsed = add_step(joy_elapsed);

		// distance classifier, stop wins over go
		if (t.obstacle_distance <= shadow_cfg.stop_dist)
			r.speed_advice = sdtc_pkg::ADV_STOP;
		else if (t.obstacle_distance < shadow_cfg.go_dist)
			r.speed_advice = sdtc_pkg::ADV_SLOW;
		else
			r.speed_advice = sdtc_pkg::ADV_GO;

		// half-step sequencer when due
		if (mot_elapsed >= {1'b0, shadow_cfg.mot_period}) begin
			if (seq_code == sdtc_pkg::SEQ_STOP)
				ns = run_en ? (turn_cw ? sdtc_pkg::SEQ_CW_ENTRY : sdtc_pkg::SEQ_CCW_ENTRY)
					: sdtc_pkg::SEQ_STOP;
			else if (seq_code <= sdtc_pkg::SEQ_LAST) begin
				ph = 3'(seq_code - 4'd1);
				ph = turn_cw ? ph - 3'd1 : ph + 3'd1;
				ns = run_en ? {1'b0, ph} + 4'd1 : sdtc_pkg::SEQ_STOP;
			end else
				ns = sdtc_pkg::SEQ_STOP;
			seq_code = ns;
			if (ns != sdtc_pkg::SEQ_STOP && ns <= sdtc_pkg::SEQ_LAST)
				coil_now = HALF_STEP[(ns - 4'd1) * 4 +: 4];
			mot_elapsed = '0;
		end
		mot_elapsed = add_step(mot_elapsed);

		// routing: mixed flags leave the ports alone
		up = |(dir_flags & sdtc_pkg::DIR_UP);
		down = |(dir_flags & sdtc_pkg::DIR_DOWN);
		left = |(dir_flags & sdtc_pkg::DIR_LEFT);
		right = |(dir_flags & sdtc_pkg::DIR_RIGHT);
		if ((up || down) && !left && !right) begin
			for (int i = 0; i < 4; i++)
				port_coils[i] = coil_now;
		end else if (left && !right && !up && !down) begin
			port_coils[0] = coil_now;
			port_coils[3] = coil_now;
		end else if (right && !left && !up && !down) begin
			port_coils[1] = coil_now;
			port_coils[2] = coil_now;
		end

		r.upper_right_coils = port_coils[0];
		r.upper_left_coils = port_coils[1];
		r.bottom_left_coils = port_coils[2];
		r.bottom_right_coils = port_coils[3];
		return r;
	endfunction

	// Tick driver: presents queued words, random gap bursts
	always @(posedge clk) begin
		if (arst_n) begin
			if (tick_valid && !tick_stall) begin
				drive_expected.push_back(predict_drive(tick_in));
				void'(tick_pending.pop_front());
			end
			if (!(tick_valid && tick_stall)) begin
				if (send_gap > 0) begin
					send_gap--;
					tick_valid <= 1'b0;
				end else if (!quiet && tick_pending.size() != 0 && $urandom_range(9, 0) == 0) begin
					send_gap = $urandom_range(10, 0);
					tick_valid <= 1'b0;
				end else if (tick_pending.size() != 0) begin
					tick_in <= tick_pending[0];
					tick_valid <= 1'b1;
				end else
					tick_valid <= 1'b0;
			end
		end
	end

	// Drive monitor: checks each taken word, random stall bursts
	always @(posedge clk) begin : drive_monitor
		sdtc_pkg::drive_t want;
		if (arst_n) begin
			if (drive_valid && !drive_stall) begin
				if (drive_expected.size() == 0)
					note_mismatch("drive word with nothing expected");
				else begin
					want = drive_expected.pop_front();
					check_field("upper_right_coils", drive_out.upper_right_coils,
						want.upper_right_coils);
					check_field("upper_left_coils", drive_out.upper_left_coils,
						want.upper_left_coils);
					check_field("bottom_left_coils", drive_out.bottom_left_coils,
						want.bottom_left_coils);
					check_field("bottom_right_coils", drive_out.bottom_right_coils,
						want.bottom_right_coils);
					check_field("speed_advice", {2'b00, drive_out.speed_advice},
						{2'b00, want.speed_advice});
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				drive_stall <= 1'b1;
			end else if (!quiet && $urandom_range(7, 0) == 0) begin
				stall_left = $urandom_range(10, 0);
				drive_stall <= 1'b1;
			end else
				drive_stall <= 1'b0;
		end
	end

	// Watchdog on cycles with no transfer on any port
	always @(posedge clk) begin
		if (arst_n) begin
			if ((tick_valid && !tick_stall) || (drive_valid && !drive_stall) ||
					(psel && penable && pwrite && pready))
				idle_cycles <= 0;
			else if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end else
				idle_cycles <= idle_cycles + 1;
		end
	end

	// APB write: setup then access, mirror updated once it lands
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			sdtc_pkg::REG_ADC_HIGH: shadow_cfg.adc_high = value[9:0];
			sdtc_pkg::REG_ADC_LOW: shadow_cfg.adc_low = value[9:0];
			sdtc_pkg::REG_STOP_DIST: shadow_cfg.stop_dist = value[7:0];
			sdtc_pkg::REG_GO_DIST: shadow_cfg.go_dist = value[7:0];
			sdtc_pkg::REG_JOY_PER: shadow_cfg.joy_period = value[11:0];
			sdtc_pkg::REG_MOT_PER: shadow_cfg.mot_period = value[11:0];
			sdtc_pkg::REG_TICK_STEP: shadow_cfg.tick_step = value[7:0];
			default: ;
		endcase
	endtask

	task automatic apply_settings(input int hi, input int lo, input int stop_d, input int go_d,
			input int joy_p, input int mot_p, input int step);
		write_reg(sdtc_pkg::REG_ADC_HIGH, hi);
		write_reg(sdtc_pkg::REG_ADC_LOW, lo);
		write_reg(sdtc_pkg::REG_STOP_DIST, stop_d);
		write_reg(sdtc_pkg::REG_GO_DIST, go_d);
		write_reg(sdtc_pkg::REG_JOY_PER, joy_p);
		write_reg(sdtc_pkg::REG_MOT_PER, mot_p);
		write_reg(sdtc_pkg::REG_TICK_STEP, step);
	endtask

	task automatic wait_drained();
		while (tick_pending.size() != 0 || drive_expected.size() != 0)
			@(posedge clk);
	endtask

	task automatic push_tick(input int v, input int h, input int d);
		sdtc_pkg::tick_t t;
		t.adc_vertical = 10'(v);
		t.adc_horizontal = 10'(h);
		t.obstacle_distance = 8'(d);
		tick_pending.push_back(t);
	endtask

	// Stick sample within a zone of the current thresholds; empty zones fall back
	function automatic logic [9:0] axis_sample(input zone_t zone);
		int hi, lo;
		hi = int'(shadow_cfg.adc_high);
		lo = int'(shadow_cfg.adc_low);
		case (zone)
			ZONE_HIGH: if (hi < 1023)
				return 10'(($urandom_range(3, 0) == 0) ? hi + 1 : $urandom_range(1023, hi + 1));
			ZONE_LOW: if (lo > 0)
				return 10'(($urandom_range(3, 0) == 0) ? lo - 1 : $urandom_range(lo - 1, 0));
			ZONE_MID: if (lo <= hi)
				return 10'($urandom_range(hi, lo));
			default: ;
		endcase
		return 10'($urandom_range(1023, 0));
	endfunction

	// Distances clustered on the classifier edges
	function automatic logic [7:0] dist_sample();
		case ($urandom_range(5, 0))
			0: return shadow_cfg.stop_dist;
			1: return shadow_cfg.stop_dist + 8'd1;
			2: return shadow_cfg.go_dist - 8'd1;
			3: return shadow_cfg.go_dist;
			4: return $urandom_range(1, 0) ? 8'd255 : 8'd0;
			default: return 8'($urandom_range(255, 0));
		endcase
	endfunction

	// Held stick runs with random content, plus some noise words
	task automatic fill_random(input int count);
		move_t move;
		int run_len;
		int made;
		sdtc_pkg::tick_t t;
		made = 0;
		while (made < count) begin
			move = move_t'($urandom_range(4, 0));
			run_len = $urandom_range(30, 3);
			for (int k = 0; k < run_len && made < count; k++) begin
				if ($urandom_range(7, 0) == 0) begin
					t.adc_vertical = 10'($urandom_range(1023, 0));
					t.adc_horizontal = 10'($urandom_range(1023, 0));
					t.obstacle_distance = 8'($urandom_range(255, 0));
				end else begin
					case (move)
						MOVE_UP: begin
							t.adc_vertical = axis_sample(ZONE_HIGH);
							t.adc_horizontal = axis_sample(ZONE_ANY);
						end
						MOVE_DOWN: begin
							t.adc_vertical = axis_sample(ZONE_LOW);
							t.adc_horizontal = axis_sample(ZONE_ANY);
						end
						MOVE_RIGHT: begin
							t.adc_vertical = axis_sample(ZONE_MID);
							t.adc_horizontal = axis_sample(ZONE_HIGH);
						end
						MOVE_LEFT: begin
							t.adc_vertical = axis_sample(ZONE_MID);
							t.adc_horizontal = axis_sample(ZONE_LOW);
						end
						default: begin
							t.adc_vertical = axis_sample(ZONE_MID);
							t.adc_horizontal = axis_sample(ZONE_MID);
						end
					endcase
					t.obstacle_distance = dist_sample();
				end
				tick_pending.push_back(t);
				made++;
			end
		end
	endtask

	// Main sequence
	initial begin
		int a, b;
		reset_model();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: first tick runs the decode and leaves the unstarted state
		push_tick(1023, 0, 255);
		push_tick(0, 1023, 0);
		push_tick(512, 512, 8);
		push_tick(700, 300, 9);
		wait_drained();

		// every task due on every tick; stick on and around each threshold
		apply_settings(700, 300, 8, 20, 1, 1, 1);
		push_tick(701, 512, 9);
		push_tick(1023, 0, 255);
		push_tick(701, 512, 19);
		push_tick(299, 512, 20);
		push_tick(0, 1023, 21);
		push_tick(0, 0, 0);
		push_tick(700, 701, 8);
		push_tick(512, 1023, 7);
		push_tick(300, 1023, 255);
		push_tick(512, 299, 10);
		push_tick(512, 0, 100);
		push_tick(650, 0, 1);
		push_tick(700, 300, 50);
		push_tick(500, 500, 200);
		push_tick(1023, 1023, 255);
		push_tick(0, 0, 0);

		for (int phase = 0; phase < 8; phase++) begin
			wait_drained();
			case (phase)
				0: apply_settings(700, 300, 8, 20, 6, 1, 1);
				// thresholds at the rails: stick never counts as pushed
				1: apply_settings(1023, 0, 0, 255, 1, 1, 255);
				// crossed thresholds, longest periods
				2: apply_settings(0, 1023, 255, 0, 4095, 4095, 255);
				// zero periods and zero step: both tasks run every tick
				3: apply_settings(600, 400, 100, 50, 0, 0, 0);
				// zero step with a nonzero motor period: motor frozen
				4: apply_settings(512, 511, 30, 60, 0, 2, 0);
				7: begin
					quiet = 1'b1;
					apply_settings(800, 200, 10, 40, 4, 2, 1);
				end
				default: begin
					a = $urandom_range(1023, 0);
					b = $urandom_range(1023, 0);
					apply_settings((a > b) ? a : b, (a > b) ? b : a, $urandom_range(255, 0),
						$urandom_range(255, 0), $urandom_range(20, 1), $urandom_range(6, 1),
						$urandom_range(8, 1));
				end
			endcase
			fill_random(PHASE_ITEMS);
		end

		wait_drained();
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

[stepper_drive_tick_controller.f]
hdl/sdtc_pkg.sv
hdl/sdtc_tick_logic.sv
hdl/stepper_drive_tick_controller.sv
hdl/sdtc_checker.sv
tb/sv/testbench.sv
